[rtl/rmq_pkg.sv]
// Shared types, constants and width helpers for the rotation matrix to quaternion block.
`default_nettype none
package rmq_pkg;

   localparam int DATA_W            = 16;
   localparam int FRAC_BITS_DEFAULT = 14;
   // Magnitude width of an off-diagonal sum or difference.
   localparam int NUM_W             = 17;
   // Quotient magnitude bits kept before saturation.
   localparam int QUO_W             = 16;

   localparam logic [1:0] CASE_TRACE = 2'd0;
   localparam logic [1:0] CASE_X     = 2'd1;
   localparam logic [1:0] CASE_Y     = 2'd2;
   localparam logic [1:0] CASE_Z     = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] elem_00;
      logic signed [DATA_W-1:0] elem_01;
      logic signed [DATA_W-1:0] elem_02;
      logic signed [DATA_W-1:0] elem_10;
      logic signed [DATA_W-1:0] elem_11;
      logic signed [DATA_W-1:0] elem_12;
      logic signed [DATA_W-1:0] elem_20;
      logic signed [DATA_W-1:0] elem_21;
      logic signed [DATA_W-1:0] elem_22;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] quat_x;
      logic signed [DATA_W-1:0] quat_y;
      logic signed [DATA_W-1:0] quat_z;
      logic signed [DATA_W-1:0] quat_w;
      logic [1:0]               case_taken;
   } rsp_type;

   // Signed width of the radicand before clamping.
   function automatic int rmq_rad_w(input int frac);
      return ((frac + 1 > 17) ? frac + 1 : 17) + 3;
   endfunction

   // Number of root bits, one pipeline stage each.
   function automatic int rmq_sqrt_w(input int frac);
      return (rmq_rad_w(frac) - 1 + frac + 1) / 2;
   endfunction

   // Cycles from an accepted transaction to its result strobe.
   function automatic int rmq_latency(input int frac);
      return rmq_sqrt_w(frac) + QUO_W + 4;
   endfunction

endpackage
`default_nettype wire

[rtl/rotation_matrix_to_quaternion.sv]
// Pipelined rotation matrix to quaternion conversion, four-case method, fixed point.
//
// One transaction is taken in every cycle; busy is always low. The result of a
// transaction appears on rsp_item for one cycle with rsp_strobe high. It passes
// through the square root, which resolves one root bit per stage (17 root bits at
// FRAC_BITS = 14), and through the three dividers, which run side by side with one
// overflow check stage and one quotient bit per stage. The receiver cannot hold
// results off, so nothing in the pipeline ever stalls.
`default_nettype none
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   localparam int RSW   = rmq_rad_w(FRAC_BITS);
   localparam int RUW   = RSW - 1;
   localparam int SQ_W  = rmq_sqrt_w(FRAC_BITS);
   localparam int VW2   = 2 * SQ_W;
   localparam int SW    = SQ_W + 1;
   localparam int DW    = NUM_W + FRAC_BITS;
   localparam int CW    = (DW > SW + QUO_W) ? DW : SW + QUO_W;
   localparam int DIV_N = QUO_W + 1;

   assign busy = 1'b0;

   // ---------------------------------------------------------------- input stage
   logic signed [DATA_W+1:0] trace_c;
   logic signed [RSW-1:0]    one_c;
   logic signed [RSW-1:0]    rad_s_c;
   logic [1:0]               sel_c;
   logic signed [NUM_W-1:0]  num_c [0:2];
   logic signed [NUM_W-1:0]  d12m21_c, d20m02_c, d01m10_c, s01p10_c, s02p20_c, s12p21_c;

   assign trace_c  = (DATA_W+2)'(req_item.elem_00) + (DATA_W+2)'(req_item.elem_11)
                   + (DATA_W+2)'(req_item.elem_22);
   assign one_c    = RSW'(1) << FRAC_BITS;
   assign d12m21_c = NUM_W'(req_item.elem_12) - NUM_W'(req_item.elem_21);
   assign d20m02_c = NUM_W'(req_item.elem_20) - NUM_W'(req_item.elem_02);
   assign d01m10_c = NUM_W'(req_item.elem_01) - NUM_W'(req_item.elem_10);
   assign s01p10_c = NUM_W'(req_item.elem_01) + NUM_W'(req_item.elem_10);
   assign s02p20_c = NUM_W'(req_item.elem_02) + NUM_W'(req_item.elem_20);
   assign s12p21_c = NUM_W'(req_item.elem_12) + NUM_W'(req_item.elem_21);

   // Case selection, radicand and the three numerators in lane order.
   always_comb begin
      if (trace_c > 0) begin
         sel_c   = CASE_TRACE;
         rad_s_c = RSW'(trace_c) + one_c;
         num_c[0] = d12m21_c; num_c[1] = d20m02_c; num_c[2] = d01m10_c;
      end else if (req_item.elem_00 > req_item.elem_11 &&
                   req_item.elem_00 > req_item.elem_22) begin
         sel_c   = CASE_X;
         rad_s_c = one_c + RSW'(req_item.elem_00) - RSW'(req_item.elem_11)
                 - RSW'(req_item.elem_22);
         num_c[0] = d12m21_c; num_c[1] = s01p10_c; num_c[2] = s02p20_c;
      end else if (req_item.elem_11 > req_item.elem_22) begin
         sel_c   = CASE_Y;
         rad_s_c = one_c + RSW'(req_item.elem_11) - RSW'(req_item.elem_00)
                 - RSW'(req_item.elem_22);
         num_c[0] = d20m02_c; num_c[1] = s01p10_c; num_c[2] = s12p21_c;
      end else begin
         sel_c   = CASE_Z;
         rad_s_c = one_c + RSW'(req_item.elem_22) - RSW'(req_item.elem_00)
                 - RSW'(req_item.elem_11);
         num_c[0] = d01m10_c; num_c[1] = s02p20_c; num_c[2] = s12p21_c;
      end
   end

   // ---------------------------------------------------------------- square root
   logic             sq_vld_ff [0:SQ_W];
   logic [VW2-1:0]   sq_v_ff   [0:SQ_W];
   logic [VW2-1:0]   sq_res_ff [0:SQ_W];
   logic [1:0]       sq_sel_ff [0:SQ_W];
   logic [NUM_W-1:0] sq_mag_ff [0:SQ_W][0:2];
   logic             sq_neg_ff [0:SQ_W][0:2];

   // The input stage clamps a negative radicand and splits numerators into sign
   // and magnitude.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= start;
      end
      sq_v_ff[0]   <= rad_s_c[RSW-1] ? '0 : (VW2'(rad_s_c[RUW-1:0]) << FRAC_BITS);
      sq_res_ff[0] <= '0;
      sq_sel_ff[0] <= sel_c;
      for (int l = 0; l < 3; l++) begin
         sq_neg_ff[0][l] <= num_c[l][NUM_W-1];
         sq_mag_ff[0][l] <= num_c[l][NUM_W-1] ? NUM_W'(-num_c[l]) : NUM_W'(num_c[l]);
      end
   end

   // One root bit per stage, most significant first.
   for (genvar i = 0; i < SQ_W; i++) begin : g_sqrt
      localparam int K = SQ_W - 1 - i;
      logic [VW2-1:0] bit_c;
      logic [VW2-1:0] trial_c;

      assign bit_c   = VW2'(1) << (2 * K);
      assign trial_c = sq_res_ff[i] + bit_c;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[i+1] <= 1'b0;
         end else begin
            sq_vld_ff[i+1] <= sq_vld_ff[i];
         end
         if (sq_v_ff[i] >= trial_c) begin
            sq_v_ff[i+1]   <= sq_v_ff[i] - trial_c;
            sq_res_ff[i+1] <= (sq_res_ff[i] >> 1) + bit_c;
         end else begin
            sq_v_ff[i+1]   <= sq_v_ff[i];
            sq_res_ff[i+1] <= sq_res_ff[i] >> 1;
         end
         sq_sel_ff[i+1] <= sq_sel_ff[i];
         sq_mag_ff[i+1] <= sq_mag_ff[i];
         sq_neg_ff[i+1] <= sq_neg_ff[i];
      end
   end

   // ---------------------------------------------------------------- dividers
   logic              dv_vld_ff  [0:DIV_N];
   logic [1:0]        dv_sel_ff  [0:DIV_N];
   logic [DATA_W-1:0] dv_qtr_ff  [0:DIV_N];
   logic [SW-1:0]     dv_s_ff    [0:DIV_N];
   logic [CW-1:0]     dv_rem_ff  [0:DIV_N][0:2];
   logic [QUO_W-1:0]  dv_quo_ff  [0:DIV_N][0:2];
   logic              dv_ovf_ff  [0:DIV_N][0:2];
   logic              dv_neg_ff  [0:DIV_N][0:2];

   logic [SQ_W-1:0]   root_c;
   logic [SQ_W-1:0]   qtr_c;

   assign root_c = sq_res_ff[SQ_W][SQ_W-1:0];
   assign qtr_c  = root_c >> 1;

   // Divisor s = 2 * root, at least one LSB; quarter of s is root / 2, saturated.
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= sq_vld_ff[SQ_W];
      end
      dv_sel_ff[0] <= sq_sel_ff[SQ_W];
      dv_qtr_ff[0] <= (qtr_c > SQ_W'(32767)) ? DATA_W'(32767) : DATA_W'(qtr_c);
      dv_s_ff[0]   <= (root_c == '0) ? SW'(1) : {root_c, 1'b0};
      for (int l = 0; l < 3; l++) begin
         dv_rem_ff[0][l] <= CW'(sq_mag_ff[SQ_W][l]) << FRAC_BITS;
         dv_quo_ff[0][l] <= '0;
         dv_ovf_ff[0][l] <= 1'b0;
         dv_neg_ff[0][l] <= sq_neg_ff[SQ_W][l];
      end
   end

   // Stage 0 flags a quotient too large for the kept bits; the rest resolve one
   // quotient bit each.
   for (genvar j = 0; j < DIV_N; j++) begin : g_div
      localparam int B = (j == 0) ? QUO_W : QUO_W - j;
      logic [CW-1:0] shifted_c;

      assign shifted_c = CW'(dv_s_ff[j]) << B;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j+1] <= 1'b0;
         end else begin
            dv_vld_ff[j+1] <= dv_vld_ff[j];
         end
         dv_sel_ff[j+1] <= dv_sel_ff[j];
         dv_qtr_ff[j+1] <= dv_qtr_ff[j];
         dv_s_ff[j+1]   <= dv_s_ff[j];
         for (int l = 0; l < 3; l++) begin
            dv_neg_ff[j+1][l] <= dv_neg_ff[j][l];
            if (j == 0) begin
               dv_rem_ff[j+1][l] <= dv_rem_ff[j][l];
               dv_quo_ff[j+1][l] <= dv_quo_ff[j][l];
               dv_ovf_ff[j+1][l] <= (dv_rem_ff[j][l] >= shifted_c);
            end else begin
               dv_ovf_ff[j+1][l] <= dv_ovf_ff[j][l];
               if (dv_rem_ff[j][l] >= shifted_c) begin
                  dv_rem_ff[j+1][l] <= dv_rem_ff[j][l] - shifted_c;
                  dv_quo_ff[j+1][l] <= dv_quo_ff[j][l] | (QUO_W'(1) << B);
               end else begin
                  dv_rem_ff[j+1][l] <= dv_rem_ff[j][l];
                  dv_quo_ff[j+1][l] <= dv_quo_ff[j][l];
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- output stage
   logic [DATA_W-1:0] lane_c [0:2];

   // Apply the sign and saturate to the signed 16-bit range.
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (!dv_neg_ff[DIV_N][l]) begin
            if (dv_ovf_ff[DIV_N][l] || dv_quo_ff[DIV_N][l][QUO_W-1]) begin
               lane_c[l] = DATA_W'(16'h7FFF);
            end else begin
               lane_c[l] = DATA_W'(dv_quo_ff[DIV_N][l]);
            end
         end else begin
            if (dv_ovf_ff[DIV_N][l] || dv_quo_ff[DIV_N][l] > QUO_W'(16'h8000)) begin
               lane_c[l] = DATA_W'(16'h8000);
            end else begin
               lane_c[l] = DATA_W'(QUO_W'(0) - dv_quo_ff[DIV_N][l]);
            end
         end
      end
   end

   logic    rsp_strobe_ff;
   rsp_type rsp_item_ff;
   rsp_type rsp_item_in;

   // Route lanes and the quarter term to the quaternion components per case.
   always_comb begin
      rsp_item_in.case_taken = dv_sel_ff[DIV_N];
      case (dv_sel_ff[DIV_N])
         CASE_TRACE: begin
            rsp_item_in.quat_x = lane_c[0];
            rsp_item_in.quat_y = lane_c[1];
            rsp_item_in.quat_z = lane_c[2];
            rsp_item_in.quat_w = dv_qtr_ff[DIV_N];
         end
         CASE_X: begin
            rsp_item_in.quat_w = lane_c[0];
            rsp_item_in.quat_y = lane_c[1];
            rsp_item_in.quat_z = lane_c[2];
            rsp_item_in.quat_x = dv_qtr_ff[DIV_N];
         end
         CASE_Y: begin
            rsp_item_in.quat_w = lane_c[0];
            rsp_item_in.quat_x = lane_c[1];
            rsp_item_in.quat_z = lane_c[2];
            rsp_item_in.quat_y = dv_qtr_ff[DIV_N];
         end
         default: begin
            rsp_item_in.quat_w = lane_c[0];
            rsp_item_in.quat_x = lane_c[1];
            rsp_item_in.quat_y = lane_c[2];
            rsp_item_in.quat_z = dv_qtr_ff[DIV_N];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_vld_ff[DIV_N];
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
`default_nettype wire

[rtl/rmq_checker.sv]
// Port-level assertions for the rotation matrix to quaternion block, with its bind.
`default_nettype none
module rmq_checker import rmq_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_item,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_item
);

   localparam int LAT = rmq_latency(FRAC_BITS);

   // Every accepted transaction yields its result after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("accepted transaction produced no result");

   // No result appears without a transaction accepted out of reset.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && !reset, LAT))
      else $error("result without a matching transaction");

   // The quarter term of the chosen case is never negative.
   a_quarter_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         ((rsp_item.case_taken == CASE_TRACE && !rsp_item.quat_w[DATA_W-1]) ||
          (rsp_item.case_taken == CASE_X && !rsp_item.quat_x[DATA_W-1]) ||
          (rsp_item.case_taken == CASE_Y && !rsp_item.quat_y[DATA_W-1]) ||
          (rsp_item.case_taken == CASE_Z && !rsp_item.quat_z[DATA_W-1])))
      else $error("quarter term of the selected case is negative");

   // The block never holds off a transaction.
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("busy raised");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
`default_nettype wire
